### rtl/core/circular_deque_assert.svh
// ----------------------------------------------------------------------------
// circular deque assertion macros
// shared property wrappers for the deque controller and datapath
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define CDQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circular_deque: assertion failed");

// next-cycle implication, disabled while reset is held
`define CDQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circular_deque: assertion failed");

`endif

### rtl/core/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types and codes for the circular deque
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH_DEF = 8;

    localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
    localparam logic [1:0] MODE_PUSH_REAR  = 2'd1;
    localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
    localparam logic [1:0] MODE_POP_REAR   = 2'd3;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic latch;
        logic exec;
    } t_dp_cmd;

endpackage

### rtl/core/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// request sequencer: capture, execute, then one-cycle result strobe
// ----------------------------------------------------------------------------
`include "circular_deque_assert.svh"

module cdq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    output logic             o_valid,
    output cdq_pkg::t_dp_cmd o_cmd
);

    cdq_pkg::t_state r_state;
    cdq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_busy      = 1'b1;
        o_valid     = 1'b0;
        o_cmd.latch = 1'b0;
        o_cmd.exec  = 1'b0;
        case (r_state)
            cdq_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = cdq_pkg::ST_EXEC;
                end
            end
            cdq_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = cdq_pkg::ST_RESP;
            end
            cdq_pkg::ST_RESP: begin
                o_valid = 1'b1;
                n_state = cdq_pkg::ST_IDLE;
            end
            default: begin
                n_state = cdq_pkg::ST_IDLE;
            end
        endcase
    end

    // every accepted request gets exactly one strobe, in the state after the execute state
    `CDQ_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, i_start && !o_busy, o_cmd.exec)
    `CDQ_ASSERT_NXT(a_exec_resp, i_clk, i_rst_n, o_cmd.exec, o_valid && o_busy)
    `CDQ_ASSERT_NXT(a_resp_idle, i_clk, i_rst_n, o_valid, !o_busy && !o_valid)

endmodule

### rtl/core/cdq_dp.sv
// ----------------------------------------------------------------------------
// cdq_dp
// ring store, front and rear indices, fill count and result registers
// ----------------------------------------------------------------------------
`include "circular_deque_assert.svh"

module cdq_dp #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cdq_pkg::t_dp_cmd   i_cmd,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_push_value,
    output logic signed [31:0] o_pop_value,
    output logic [1:0]         o_status,
    output logic [3:0]         o_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic signed [31:0] r_store [DEPTH];

    logic [1:0]         r_mode;
    logic signed [31:0] r_push_value;
    logic [AW-1:0]      r_head;
    logic [AW-1:0]      r_tail;
    logic [CW-1:0]      r_count;
    logic [1:0]         r_status;
    logic               r_pop_ok;
    logic signed [31:0] r_rd_data;

    logic [AW-1:0] n_head;
    logic [AW-1:0] n_tail;
    logic [CW-1:0] n_count;
    logic [1:0]    n_status;
    logic          n_pop_ok;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          is_push;
    logic          is_full;
    logic          is_empty;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] tail_inc;
    logic [AW-1:0] tail_dec;
    logic [CW+3:0] occ_ext;
    logic          uflow_chk;
    logic          oflow_chk;
    logic          uflow_seen;
    logic          oflow_seen;

    assign is_push  = (r_mode == cdq_pkg::MODE_PUSH_FRONT) ||
                      (r_mode == cdq_pkg::MODE_PUSH_REAR);
    assign is_full  = (r_count == FULL_CNT);
    assign is_empty = (r_count == '0);
    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
    assign head_dec = (r_head == '0) ? LAST_IDX : r_head - AW'(1);
    assign tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + AW'(1);
    assign tail_dec = (r_tail == '0) ? LAST_IDX : r_tail - AW'(1);

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = cdq_pkg::STATUS_DONE;
        n_pop_ok = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        rd_addr  = r_head;
        case (r_mode)
            cdq_pkg::MODE_PUSH_FRONT, cdq_pkg::MODE_PUSH_REAR: begin
                if (is_full) begin
                    n_status = cdq_pkg::STATUS_OVERFLOW;
                end else if (is_empty) begin
                    // first entry always lands at slot zero
                    n_head  = '0;
                    n_tail  = '0;
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    n_count = r_count + CW'(1);
                end else if (r_mode == cdq_pkg::MODE_PUSH_FRONT) begin
                    n_head  = head_dec;
                    wr_en   = 1'b1;
                    wr_addr = head_dec;
                    n_count = r_count + CW'(1);
                end else begin
                    n_tail  = tail_inc;
                    wr_en   = 1'b1;
                    wr_addr = tail_inc;
                    n_count = r_count + CW'(1);
                end
            end
            cdq_pkg::MODE_POP_FRONT: begin
                rd_addr = r_head;
                if (is_empty) begin
                    n_status = cdq_pkg::STATUS_UNDERFLOW;
                end else begin
                    n_pop_ok = 1'b1;
                    n_count  = r_count - CW'(1);
                    if (r_head == r_tail) begin
                        n_head = '0;
                        n_tail = '0;
                    end else begin
                        n_head = head_inc;
                    end
                end
            end
            cdq_pkg::MODE_POP_REAR: begin
                rd_addr = r_tail;
                if (is_empty) begin
                    n_status = cdq_pkg::STATUS_UNDERFLOW;
                end else begin
                    n_pop_ok = 1'b1;
                    n_count  = r_count - CW'(1);
                    if (r_head == r_tail) begin
                        n_head = '0;
                        n_tail = '0;
                    end else begin
                        n_tail = tail_dec;
                    end
                end
            end
            default: begin
                n_status = cdq_pkg::STATUS_DONE;
            end
        endcase
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode       <= i_mode;
            r_push_value <= i_push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
    end

    // ring store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_store[wr_addr] <= r_push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    assign occ_ext     = {4'b0000, r_count};
    assign o_occupancy = occ_ext[3:0];
    assign o_status    = r_status;
    assign o_pop_value = r_pop_ok ? r_rd_data : 32'sd0;

    assign uflow_chk  = i_cmd.exec && !is_push && is_empty;
    assign oflow_chk  = i_cmd.exec && is_push && is_full;
    assign uflow_seen = (r_status == cdq_pkg::STATUS_UNDERFLOW) && (r_count == '0);
    assign oflow_seen = (r_status == cdq_pkg::STATUS_OVERFLOW) && (r_count == FULL_CNT);

    `CDQ_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT)
    `CDQ_ASSERT_NXT(a_underflow, i_clk, i_rst_n, uflow_chk, uflow_seen)
    `CDQ_ASSERT_NXT(a_overflow_hold, i_clk, i_rst_n, oflow_chk, oflow_seen && $stable(r_head))

endmodule

### rtl/core/circular_deque.sv
// the result strobe is given in the response state, which follows the execute state
// new requests wait for the capture/execute/strobe controller: busy is high in its execute and strobe states
// the store read is registered in the execute cycle and shown in the strobe cycle
// reset (synchronous, active low) empties the deque; store contents are not cleared
// the receiver cannot stall: each result is valid for exactly one cycle
// ----------------------------------------------------------------------------
// circular_deque
// fixed-depth ring-buffer double-ended queue with push/pop at both ends
// ----------------------------------------------------------------------------
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_push_value,
    output logic               o_valid,
    output logic signed [31:0] o_pop_value,
    output logic [1:0]         o_status,
    output logic [3:0]         o_occupancy
);

    cdq_pkg::t_dp_cmd cmd;

    cdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    cdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

endmodule
